// ===== rtl/olid_pkg.sv =====
// ---------------------------------------------------------------------------
// olid_pkg - shared types for the ordered list
// Command, status and cell operation codes used by the list top and its cells.
// ---------------------------------------------------------------------------
package olid_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int VAL_W         = 32;
  localparam int POS_W         = 8;
  localparam int CNT_OUT_W     = 7;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DUMP      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  // per-cycle operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,  // cells above idx take left neighbor, cell idx takes new value
    CELL_SHIFT  = 2'd2,  // all cells take right neighbor
    CELL_ROTATE = 2'd3   // cells below idx take right neighbor, cell idx takes head
  } cell_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

endpackage

// ===== rtl/olid_cell.sv =====
// ---------------------------------------------------------------------------
// olid_cell - one storage cell of the list chain
// Holds one entry and updates from its neighbors, the head or the new value.
// ---------------------------------------------------------------------------
module olid_cell import olid_pkg::*; #(
  parameter int IW    = 6,
  parameter int INDEX = 0
) (
  input  logic                    clk,
  input  cell_op_t                op,
  input  logic [IW-1:0]           idx,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [VAL_W-1:0] right_val,
  input  logic signed [VAL_W-1:0] head_val,
  input  logic signed [VAL_W-1:0] new_val,
  output logic signed [VAL_W-1:0] val
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic signed [VAL_W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (op)
      CELL_INSERT: begin
        if (MY_IDX == idx) begin
          val_next = new_val;
        end else if (MY_IDX > idx) begin
          val_next = left_val;
        end
      end
      CELL_SHIFT: begin
        val_next = right_val;
      end
      CELL_ROTATE: begin
        if (MY_IDX == idx) begin
          val_next = head_val;
        end else if (MY_IDX < idx) begin
          val_next = right_val;
        end
      end
      default: begin
        val_next = val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== rtl/ordered_list_insert_delete.sv =====
// ---------------------------------------------------------------------------
// ordered_list_insert_delete - bounded ordered list of signed 32-bit values
// Chain of DEPTH cells that shift in parallel; front/back/position insert,
// front/back delete and an in-order dump.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one command per item. s_tuser carries the command,
//   s_tdata the value and the 1-based position.
//   Output channel m_*: result items. Every command gives one item, except
//   a dump of a non-empty list, which gives one item per entry, front first.
//   m_tlast marks the final item of a command.
// Flow:
//   Insert and delete finish in the accept cycle (all cells shift at once);
//   the result shows on m_* the next cycle. With m_tready high and no dump
//   running the block takes one command per cycle. A dump of N entries loads
//   its counter in the accept cycle, then the chain rotates one step per
//   result and the head cell is read out into the result register from the
//   dump state; the list is back in place when the last item leaves.
//   s_tready stays low while the block is in the dump state, until the
//   last entry has been loaded into the result register.
// Reset: rst (synchronous) empties the list and drops m_tvalid; cell
//   contents are not cleared, only entries below the count are ever read.
// Stall: with m_tready low the result register holds its item and s_tready
//   drops until the register is free again; a dump pauses in place.
// ---------------------------------------------------------------------------
module ordered_list_insert_delete import olid_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] value, [39:32] position
  input  logic [2:0]  s_tuser,   // [2:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [1:0] status, [8:2] entry_count,
                                 // [40:9] entry_value, [47:41] zero
  output logic [0:0]  m_tuser,   // [0] entry_valid
  output logic        m_tlast    // last
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // cell index width
  localparam int CW   = $clog2(DEPTH + 1);                // count width
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;  // position compare width
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // input fields
  cmd_t                    in_cmd;
  logic signed [VAL_W-1:0] in_value;
  logic [POS_W-1:0]        in_pos;

  assign in_cmd   = cmd_t'(s_tuser);
  assign in_value = $signed(s_tdata[VAL_W-1:0]);
  assign in_pos   = s_tdata[VAL_W+POS_W-1:VAL_W];

  // control state
  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] dump_left, dump_left_next;

  // result register
  status_t                 out_status;
  logic [CW-1:0]           out_count;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_flag;
  logic                    out_last;

  // next result
  logic                    load;
  status_t                 res_status;
  logic signed [VAL_W-1:0] res_value;
  logic                    res_flag;
  logic                    res_last;

  // chain control
  cell_op_t                cell_op;
  logic [IW-1:0]           cell_idx;
  logic signed [VAL_W-1:0] cells [DEPTH];
  logic signed [VAL_W-1:0] head;

  logic s_accept, slot_free, full, empty, pos_ok;
  logic [CMPW-1:0] pos_w, lim_w;

  assign head      = cells[0];
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && slot_free;
  assign s_accept  = s_tvalid && s_tready;
  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);

  // position must lie in 1 .. count+1
  assign pos_w  = CMPW'(in_pos);
  assign lim_w  = CMPW'(count) + CMPW'(1);
  assign pos_ok = (pos_w != '0) && (pos_w <= lim_w);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_accept && in_cmd == CMD_DUMP && !empty) begin
          state_next = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (slot_free && dump_left == CW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command decode and chain control
  always_comb begin
    cell_op        = CELL_HOLD;
    cell_idx       = '0;
    count_next     = count;
    dump_left_next = dump_left;
    load           = 1'b0;
    res_status     = STAT_OK;
    res_value      = '0;
    res_flag       = 1'b0;
    res_last       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          load = 1'b1;
          case (in_cmd)
            CMD_INS_FRONT: begin
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                cell_op    = CELL_INSERT;
                cell_idx   = '0;
                count_next = count + CW'(1);
              end
            end
            CMD_INS_BACK: begin
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                cell_op    = CELL_INSERT;
                cell_idx   = IW'(count);
                count_next = count + CW'(1);
              end
            end
            CMD_INS_POS: begin
              if (!pos_ok) begin
                res_status = STAT_BADPOS;
              end else if (full) begin
                res_status = STAT_FULL;
              end else begin
                cell_op    = CELL_INSERT;
                cell_idx   = IW'(pos_w - CMPW'(1));
                count_next = count + CW'(1);
              end
            end
            CMD_DEL_FRONT: begin
              if (empty) begin
                res_status = STAT_EMPTY;
              end else begin
                cell_op    = CELL_SHIFT;
                count_next = count - CW'(1);
              end
            end
            CMD_DEL_BACK: begin
              if (empty) begin
                res_status = STAT_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            CMD_DUMP: begin
              // empty list: a single blank result; otherwise stream entries
              if (!empty) begin
                load           = 1'b0;
                dump_left_next = count;
              end
            end
            default: begin
              res_status = STAT_OK;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          load           = 1'b1;
          cell_op        = CELL_ROTATE;
          cell_idx       = IW'(count - CW'(1));
          res_value      = head;
          res_flag       = 1'b1;
          res_last       = (dump_left == CW'(1));
          dump_left_next = dump_left - CW'(1);
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dump_left <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dump_left <= dump_left_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload, count reported after the command
  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= res_status;
      out_count  <= count_next;
      out_value  <= res_value;
      out_flag   <= res_flag;
      out_last   <= res_last;
    end
  end

  assign m_tdata = {7'd0, out_value, CNT_OUT_W'(out_count), out_status};
  assign m_tuser = out_flag;
  assign m_tlast = out_last;

  // the chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_val = in_value;
    end else begin : g_mid_l
      assign left_val = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cells[g+1];
    end
    olid_cell #(
      .IW    (IW),
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .idx       (cell_idx),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (head),
      .new_val   (in_value),
      .val       (cells[g])
    );
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above depth");

  a_dump_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DUMP |-> dump_left != '0 && dump_left <= count)
    else $error("dump counter out of range");

  a_count_on_accept: assert property (@(posedge clk) disable iff (rst)
    !(s_tvalid && s_tready) |=> $stable(count))
    else $error("count changed without a command");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == ST_DUMP |-> !s_tready)
    else $error("input taken during dump");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench - self-checking bench for ordered_list_insert_delete
// Drives list commands on the s_* stream with random gaps, mirrors the list in
// a queue-based scoreboard and checks every m_* result item field by field.
// The run covers empty and full lists, bad positions, unused command codes,
// long dumps, and a long stretch of output back-pressure.
// ---------------------------------------------------------------------------
module testbench;
  import olid_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEFAULT;
  localparam int ITEM_TARGET  = 380;
  localparam int DRAIN_LIMIT  = 20000;  // cycles allowed for results to drain
  localparam int TAIL_CYCLES  = 16;     // quiet cycles to catch stray items
  localparam int HOLD_CYCLES  = 400;    // long receiver stall

  // codes outside cmd_t; the block must treat them as no-ops
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // one expected result item
  typedef struct {
    status_t     status;
    logic [6:0]  count;
    logic [31:0] value;
    logic        valid;
    logic        last;
  } list_result_t;

  // -------------------------------------------------------------------------
  // Scoreboard: shadow copy of the list plus the queue of pending results.
  // -------------------------------------------------------------------------
  class list_scoreboard;
    logic [31:0]  cells[$];
    list_result_t pending[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    function void add_result(status_t st, logic [31:0] v, logic vld, logic lst);
      list_result_t r;
      r.status = st;
      r.count  = 7'(cells.size());
      r.value  = v;
      r.valid  = vld;
      r.last   = lst;
      pending.push_back(r);
    endfunction

    // apply one accepted command to the shadow list, queue its results
    function void note_command(logic [2:0] cmd, logic [31:0] value, logic [7:0] pos);
      status_t st;
      int      n;
      st = STAT_OK;
      n  = cells.size();
      case (cmd)
        CMD_INS_FRONT: begin
          if (n >= olid_pkg::DEPTH_DEFAULT) st = STAT_FULL;
          else cells.push_front(value);
        end
        CMD_INS_BACK: begin
          if (n >= olid_pkg::DEPTH_DEFAULT) st = STAT_FULL;
          else cells.push_back(value);
        end
        CMD_INS_POS: begin
          // position check wins over the full check
          if (int'(pos) < 1 || int'(pos) > n + 1) st = STAT_BADPOS;
          else if (n >= olid_pkg::DEPTH_DEFAULT) st = STAT_FULL;
          else cells.insert(int'(pos) - 1, value);
        end
        CMD_DEL_FRONT: begin
          if (n == 0) st = STAT_EMPTY;
          else void'(cells.pop_front());
        end
        CMD_DEL_BACK: begin
          if (n == 0) st = STAT_EMPTY;
          else void'(cells.pop_back());
        end
        CMD_DUMP: begin
          if (n == 0) begin
            add_result(STAT_OK, '0, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < n; i++)
              add_result(STAT_OK, cells[i], 1'b1, i == n - 1);
          end
          return;
        end
        default: ;
      endcase
      add_result(st, '0, 1'b0, 1'b1);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [47:0] data, logic vld, logic lst);
      list_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected item data=%h valid=%b last=%b", data, vld, lst));
        return;
      end
      e = pending.pop_front();
      if (data[1:0] !== e.status)
        report($sformatf("status got %0d exp %0d", data[1:0], e.status));
      if (data[8:2] !== e.count)
        report($sformatf("entry_count got %0d exp %0d", data[8:2], e.count));
      if (data[40:9] !== e.value)
        report($sformatf("entry_value got %h exp %h", data[40:9], e.value));
      if (data[47:41] !== 7'd0)
        report($sformatf("pad bits got %h exp 0", data[47:41]));
      if (vld !== e.valid)
        report($sformatf("entry_valid got %b exp %b", vld, e.valid));
      if (lst !== e.last)
        report($sformatf("last got %b exp %b", lst, e.last));
    endtask
  endclass

  // -------------------------------------------------------------------------
  // DUT and signals
  // -------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [31:0] value, [39:32] position
  logic [2:0]  s_tuser;   // [2:0] cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // [1:0] status, [8:2] entry_count, [40:9] entry_value
  logic [0:0]  m_tuser;   // [0] entry_valid
  logic        m_tlast;

  ordered_list_insert_delete #(.DEPTH(LIST_DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  list_scoreboard sb;
  int             idle_pct;     // chance per cycle that a side idles
  logic           hold_off;     // forces m_tready low, set at posedge only
  int             items_sent;

  // clock, 10 ns
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver: random ready, changed at the falling edge. hold_off overrides.
  // -------------------------------------------------------------------------
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= !hold_off && ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // result check at the rising edge, before the block updates its outputs
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tuser[0], m_tlast);
  end

  // -------------------------------------------------------------------------
  // Sender tasks. Each is entered and left at a falling edge.
  // -------------------------------------------------------------------------
  task automatic send_cmd(logic [2:0] cmd, logic [31:0] value, logic [7:0] pos);
    // random gap first; valid only drops on cycles actually spent idle
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pos, value};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    sb.note_command(cmd, value, pos);
    items_sent++;
    @(negedge clk);
  endtask

  // mostly random values, now and then an extreme
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // well-formed insert at front, back or a legal position
  task automatic insert_random();
    int n;
    n = sb.cells.size();
    case ($urandom_range(0, 2))
      0:       send_cmd(CMD_INS_FRONT, pick_value(), 8'($urandom));
      1:       send_cmd(CMD_INS_BACK, pick_value(), 8'($urandom));
      default: send_cmd(CMD_INS_POS, pick_value(), 8'($urandom_range(1, n + 1)));
    endcase
  endtask

  // position 0 or anything past count+1
  task automatic insert_badpos();
    logic [7:0] p;
    if ($urandom_range(0, 3) == 0) p = 8'd0;
    else p = 8'($urandom_range(sb.cells.size() + 2, 255));
    send_cmd(CMD_INS_POS, pick_value(), p);
  endtask

  task automatic random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) insert_random();
    else if (r < 55) insert_badpos();
    else if (r < 70) send_cmd(CMD_DEL_FRONT, $urandom, 8'($urandom));
    else if (r < 85) send_cmd(CMD_DEL_BACK, $urandom, 8'($urandom));
    else if (r < 93) send_cmd(CMD_DUMP, $urandom, 8'($urandom));
    else send_cmd($urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7, $urandom, 8'($urandom));
  endtask

  // fill to capacity, poke the full list, then drain past empty
  task automatic fill_and_drain();
    while (sb.cells.size() < LIST_DEPTH) insert_random();
    send_cmd(CMD_INS_FRONT, pick_value(), 8'($urandom));
    send_cmd(CMD_INS_BACK, pick_value(), 8'($urandom));
    send_cmd(CMD_INS_POS, pick_value(), 8'($urandom_range(1, LIST_DEPTH + 1)));
    // bad position reported ahead of full
    send_cmd(CMD_INS_POS, pick_value(), 8'(LIST_DEPTH + 2));
    send_cmd(CMD_DUMP, $urandom, 8'($urandom));
    while (sb.cells.size() > 0) begin
      if ($urandom_range(0, 19) == 0) send_cmd(CMD_DUMP, $urandom, 8'($urandom));
      else send_cmd($urandom_range(0, 1) ? CMD_DEL_FRONT : CMD_DEL_BACK,
                    $urandom, 8'($urandom));
    end
    send_cmd(CMD_DEL_FRONT, $urandom, 8'($urandom));
    send_cmd(CMD_DUMP, $urandom, 8'($urandom));
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int waited;
    sb         = new();
    idle_pct   = 34;
    hold_off   = 1'b0;
    items_sent = 0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty-list corners, extremes, every command, unused codes
    send_cmd(CMD_DUMP, $urandom, 8'($urandom));
    send_cmd(CMD_DEL_FRONT, $urandom, 8'($urandom));
    send_cmd(CMD_DEL_BACK, $urandom, 8'($urandom));
    send_cmd(CMD_INS_POS, 32'h1234_5678, 8'd0);
    send_cmd(CMD_INS_POS, 32'h1234_5678, 8'd2);
    send_cmd(CMD_INS_POS, 32'h8000_0000, 8'd1);
    send_cmd(CMD_INS_FRONT, 32'h7FFF_FFFF, 8'hFF);
    send_cmd(CMD_INS_BACK, 32'hFFFF_FFFF, 8'h00);
    send_cmd(CMD_INS_BACK, 32'h0000_0000, 8'hAA);
    send_cmd(CMD_INS_POS, 32'h0000_0001, 8'd5);   // count+1: append
    send_cmd(CMD_INS_POS, 32'hA5A5_5A5A, 8'd2);   // middle
    send_cmd(CMD_INS_POS, 32'h5555_AAAA, 8'hFF);
    send_cmd(CMD_INS_POS, 32'h5555_AAAA, 8'd8);   // count+2
    send_cmd(CMD_DUMP, $urandom, 8'($urandom));
    send_cmd(CMD_RSVD6, $urandom, 8'($urandom));
    send_cmd(CMD_RSVD7, $urandom, 8'($urandom));
    send_cmd(CMD_DEL_FRONT, $urandom, 8'($urandom));
    send_cmd(CMD_DEL_BACK, $urandom, 8'($urandom));
    send_cmd(CMD_DUMP, $urandom, 8'($urandom));

    // back-to-back stretch: no idling on either side
    idle_pct = 0;
    fill_and_drain();
    idle_pct = 34;

    // long receiver stall while the sender keeps offering, so the block
    // backs up and drops s_tready
    fork
      begin
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    fill_and_drain();

    // mixed random traffic, lists stay mostly short
    while (items_sent < ITEM_TARGET) random_command();
    s_tvalid <= 1'b0;

    // let every expected item come out, then watch for strays
    waited = 0;
    while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected items never arrived", sb.pending.size()));
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
